>>> design/pmcb_pkg.sv
// Package for the price move circuit breaker: field widths, opcodes, register
// indexes, controller states and the result record.
// No dependencies.
`default_nettype none

package pmcb_pkg;

  localparam int TIME_BITS   = 48;
  localparam int WINDOW_BITS = 16;
  localparam int MOVE_BITS   = 20;
  localparam int CFG_BITS    = 20;
  localparam int SCALE_BITS  = 14;
  localparam int LIMIT_BITS  = 37;
  localparam int BPS_TERMS   = 5;

  localparam logic [MOVE_BITS-1:0]   MOVE_MAX        = '1;
  localparam logic [19:0]            US_PER_SECOND   = 20'd1000000;
  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET    = 16'd60;
  localparam logic [MOVE_BITS-1:0]   THRESHOLD_RESET = 20'd1000;

  localparam logic [1:0] OP_TRADE  = 2'd0;
  localparam logic [1:0] OP_RESUME = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic CFG_WINDOW_SECONDS = 1'b0;
  localparam logic CFG_HALT_THRESHOLD = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_TRIP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 halted;
    logic                 tripped;
    logic                 window_restarted;
    logic                 move_valid;
    logic [MOVE_BITS-1:0] move_bps;
  } result_t;

  // basis point scale as a sum of powers of two: 8192 + 1024 + 512 + 256 + 16
  function automatic logic [3:0] bps_shift(input logic [2:0] k);
    logic [3:0] s;
    case (k)
      3'd0:    s = 4'd13;
      3'd1:    s = 4'd10;
      3'd2:    s = 4'd9;
      3'd3:    s = 4'd8;
      3'd4:    s = 4'd4;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/price_move_circuit_breaker_core.sv
// Price move circuit breaker: per-symbol reference table, window check and
// bit-serial move computation with halt tracking.
// Depends on pmcb_pkg.
//
// Use: configuration writes go through cfg_write_en, cfg_index and cfg_data
// (index 0 window seconds, index 1 halt threshold in basis points) while the
// block is idle. Items enter on in_valid/in_ready, one at a time; each item
// gives exactly one result on out_valid/out_ready.
// For a trade that computes a move, a shift-add over the five power-of-two terms
// of the basis point scale scales the price difference, then a restoring divider
// takes one quotient bit per cycle over PRICE_BITS + 14 bits. in_ready returns
// in the same cycle that the result shows on out_valid.
// After reset the table is swept clear, one entry per cycle, over all NUM_SYMBOLS
// entries; in_ready stays low during the sweep, configuration writes are taken.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and its result waits until that register is taken.
`default_nettype none

module price_move_circuit_breaker_core
  import pmcb_pkg::*;
#(
  parameter int NUM_SYMBOLS = 256,
  parameter int PRICE_BITS  = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_BITS-1:0]  cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           opcode,
  input  wire logic [7:0]           symbol_index,
  input  wire logic [47:0]          trade_price,
  input  wire logic [TIME_BITS-1:0] now_us,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      halted,
  output logic                      tripped,
  output logic                      window_restarted,
  output logic                      move_valid,
  output logic [MOVE_BITS-1:0]      move_bps
);

  localparam int AW        = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int NB        = PRICE_BITS + SCALE_BITS;
  localparam int CW        = $clog2(NB + 1);
  localparam int ROW_W     = 2 + PRICE_BITS + TIME_BITS;
  localparam int ROW_HALT  = ROW_W - 1;
  localparam int ROW_VALID = ROW_W - 2;

  state_t state, state_next;

  logic [WINDOW_BITS-1:0] window_len;
  logic [MOVE_BITS-1:0]   trip_limit;
  logic [LIMIT_BITS-1:0]  limit;
  logic [WINDOW_BITS:0]   window_plus_one;

  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         sym_addr;
  logic [AW+7:0]         sym_wide;
  logic                  in_range;
  logic [1:0]            op;
  logic [PRICE_BITS-1:0] price;
  logic [TIME_BITS-1:0]  now;

  logic [ROW_W-1:0] mem [NUM_SYMBOLS];
  logic [ROW_W-1:0] rd_row;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  logic                  row_halt;
  logic                  row_valid;
  logic [PRICE_BITS-1:0] row_ref;
  logic [TIME_BITS-1:0]  row_start;

  logic [TIME_BITS-1:0]  tdiff;
  logic                  t_ge;
  logic                  restart;
  logic [PRICE_BITS-1:0] diff;
  logic [NB-1:0]         prod;
  logic [NB-1:0]         term;
  logic [PRICE_BITS-1:0] rem;
  logic [PRICE_BITS:0]   rem_shift;
  logic [PRICE_BITS:0]   rem_sub;
  logic                  rem_ge;
  logic [MOVE_BITS-1:0]  quo;
  logic                  over;
  logic                  move_gt;
  logic [MOVE_BITS-1:0]  move_out;
  logic [CW-1:0]         step;

  result_t res;
  result_t out_res;

  assign row_halt  = rd_row[ROW_HALT];
  assign row_valid = rd_row[ROW_VALID];
  assign row_ref   = rd_row[PRICE_BITS+TIME_BITS-1:TIME_BITS];
  assign row_start = rd_row[TIME_BITS-1:0];

  assign sym_wide        = {{AW{1'b0}}, symbol_index};
  assign window_plus_one = {1'b0, window_len} + {{WINDOW_BITS{1'b0}}, 1'b1};

  assign restart   = t_ge && (tdiff >= TIME_BITS'(limit));
  assign term      = {{SCALE_BITS{1'b0}}, diff} << bps_shift(step[2:0]);
  assign rem_shift = {rem, prod[NB-1]};
  assign rem_ge    = rem_shift >= {1'b0, row_ref};
  assign rem_sub   = rem_shift - {1'b0, row_ref};
  assign move_gt   = over || (quo > trip_limit);
  assign move_out  = over ? MOVE_MAX : quo;

  assign halted           = out_res.halted;
  assign tripped          = out_res.tripped;
  assign window_restarted = out_res.window_restarted;
  assign move_valid       = out_res.move_valid;
  assign move_bps         = out_res.move_bps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = sym_addr;
    mem_wdata  = rd_row;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == AW'(NUM_SYMBOLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_DONE;
        if (in_range) begin
          case (op)
            OP_TRADE: begin
              if (row_valid) begin
                state_next = ST_CHECK;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {row_halt, 1'b1, price, now};
              end
            end
            OP_RESUME: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (restart) begin
          mem_we     = 1'b1;
          mem_wdata  = {row_halt, 1'b1, price, now};
          state_next = ST_DONE;
        end else if (row_ref == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step == CW'(BPS_TERMS - 1)) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == CW'(1)) begin
          state_next = ST_TRIP;
        end
      end
      ST_TRIP: begin
        if (move_gt) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, rd_row[ROW_W-2:0]};
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row <= mem[sym_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      window_len <= WINDOW_RESET;
      trip_limit <= THRESHOLD_RESET;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_WINDOW_SECONDS: window_len <= cfg_data[WINDOW_BITS-1:0];
          CFG_HALT_THRESHOLD: trip_limit <= cfg_data[MOVE_BITS-1:0];
        endcase
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit <= LIMIT_BITS'(window_plus_one) * LIMIT_BITS'(US_PER_SECOND);
    if (state == ST_IDLE && in_valid) begin
      op       <= opcode;
      sym_addr <= sym_wide[AW-1:0];
      in_range <= sym_wide < (AW + 8)'(NUM_SYMBOLS);
      price    <= trade_price[PRICE_BITS-1:0];
      now      <= now_us;
    end
    case (state)
      ST_LOOKUP: begin
        tdiff <= now - row_start;
        t_ge  <= now >= row_start;
        res   <= {in_range && (op != OP_RESUME) && row_halt, 1'b0,
                  in_range && (op == OP_TRADE) && !row_valid, 1'b0,
                  {MOVE_BITS{1'b0}}};
      end
      ST_CHECK: begin
        diff <= (price >= row_ref) ? price - row_ref : row_ref - price;
        prod <= '0;
        step <= '0;
        if (restart) begin
          res.window_restarted <= 1'b1;
        end
      end
      ST_MUL: begin
        prod <= prod + term;
        if (step == CW'(BPS_TERMS - 1)) begin
          step <= CW'(NB);
          rem  <= '0;
          quo  <= '0;
          over <= 1'b0;
        end else begin
          step <= step + CW'(1);
        end
      end
      ST_DIV: begin
        rem  <= rem_ge ? rem_sub[PRICE_BITS-1:0] : rem_shift[PRICE_BITS-1:0];
        prod <= prod << 1;
        quo  <= {quo[MOVE_BITS-2:0], rem_ge};
        over <= over | quo[MOVE_BITS-1];
        step <= step - CW'(1);
      end
      ST_TRIP: begin
        res.move_valid <= 1'b1;
        res.move_bps   <= move_out;
        res.tripped    <= move_gt;
        if (move_gt) begin
          res.halted <= 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_res <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/pmcb_checker.sv
// Port-level checks for the price move circuit breaker, bound to the top level.
// Depends on pmcb_pkg and price_move_circuit_breaker_core.
`default_nettype none

module pmcb_checker
  import pmcb_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 halted,
  input wire logic                 tripped,
  input wire logic                 window_restarted,
  input wire logic                 move_valid,
  input wire logic [MOVE_BITS-1:0] move_bps
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(move_bps) && $stable(halted))
    else $error("result changed while stalled");

  a_no_move_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !move_valid |-> move_bps == '0 && !tripped)
    else $error("move fields set without a computed move");

  a_trip_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && tripped |-> halted && move_valid)
    else $error("tripped item not halted");

  a_restart_no_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_restarted |-> !move_valid)
    else $error("restarted window also computed a move");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("ports active right after reset");

endmodule

bind price_move_circuit_breaker_core pmcb_checker u_pmcb_checker (.*);

`default_nettype wire
